// ===== hw/rtl/sha1s_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1s_pkg
// shared types and constants of the sha-1 stream hasher
// ----------------------------------------------------------------------------
package sha1s_pkg;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam int ROUNDS      = 80;
   localparam int DIGEST_WORDS = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH,
      ST_PAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_byte;   // shift in the request byte and count its length
      logic pad_byte;    // shift in one padding byte
      logic pad_first;   // padding byte is the 0x80 mark
      logic pad_extra;   // length field is deferred to a following extra padding block
      logic begin_block; // load working registers from the chaining value
      logic round;       // run one compression round
      logic finish;      // add working registers into the chaining value
      logic emit_next;   // advance to the next digest word
      logic emit_done;   // restart chaining value and length for a new message
   } dp_cmd_type;

   typedef struct packed {
      logic pos_last;   // fill position is the last byte of the block
      logic pos_ge56;   // fill position lies in the length field
      logic round_last; // final compression round
      logic word_last;  // last digest word
   } dp_status_type;

endpackage

// ===== hw/rtl/sha1s_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1s_ctrl
// sequencer for byte intake, block compression, padding and digest output
// ----------------------------------------------------------------------------
module sha1s_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_tuser,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output sha1s_pkg::dp_cmd_type    cmd,
   input  sha1s_pkg::dp_status_type status
);

   sha1s_pkg::state_type state_ff, state_in;
   logic eom_pending_ff, eom_pending_in;
   logic pad_first_ff, pad_first_in;
   logic pad_extra_ff, pad_extra_in;
   logic padding_ff, padding_in;
   logic req_acc;
   logic rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // next state
   always_comb begin
      state_in       = state_ff;
      eom_pending_in = eom_pending_ff;
      pad_first_in   = pad_first_ff;
      pad_extra_in   = pad_extra_ff;
      padding_in     = padding_ff;
      unique case (state_ff)
         sha1s_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser && status.pos_last) begin
                  eom_pending_in = req_tlast;
                  padding_in     = 1'b0;
                  state_in       = sha1s_pkg::ST_ROUND;
               end else if (req_tlast) begin
                  pad_first_in = 1'b1;
                  state_in     = sha1s_pkg::ST_PAD;
               end
            end
         end
         sha1s_pkg::ST_ROUND: begin
            if (status.round_last) begin
               state_in = sha1s_pkg::ST_FINISH;
            end
         end
         sha1s_pkg::ST_FINISH: begin
            if (padding_ff) begin
               if (pad_extra_ff) begin
                  pad_extra_in = 1'b0;
                  state_in     = sha1s_pkg::ST_PAD;
               end else begin
                  state_in = sha1s_pkg::ST_EMIT;
               end
            end else if (eom_pending_ff) begin
               eom_pending_in = 1'b0;
               pad_first_in   = 1'b1;
               state_in       = sha1s_pkg::ST_PAD;
            end else begin
               state_in = sha1s_pkg::ST_IDLE;
            end
         end
         sha1s_pkg::ST_PAD: begin
            pad_first_in = 1'b0;
            if (pad_first_ff) begin
               pad_extra_in = status.pos_ge56;
            end
            if (status.pos_last) begin
               padding_in = 1'b1;
               state_in   = sha1s_pkg::ST_ROUND;
            end
         end
         sha1s_pkg::ST_EMIT: begin
            if (rsp_acc && status.word_last) begin
               state_in = sha1s_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha1s_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         sha1s_pkg::ST_IDLE: begin
            req_tready      = 1'b1;
            cmd.load_byte   = req_acc && req_tuser;
            cmd.begin_block = req_acc && req_tuser && status.pos_last;
         end
         sha1s_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
         end
         sha1s_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         sha1s_pkg::ST_PAD: begin
            cmd.pad_byte    = 1'b1;
            cmd.pad_first   = pad_first_ff;
            cmd.pad_extra   = pad_extra_ff;
            cmd.begin_block = status.pos_last;
         end
         sha1s_pkg::ST_EMIT: begin
            rsp_tvalid    = 1'b1;
            cmd.emit_next = rsp_acc;
            cmd.emit_done = rsp_acc && status.word_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sha1s_pkg::ST_IDLE;
         eom_pending_ff <= 1'b0;
         pad_first_ff   <= 1'b0;
         pad_extra_ff   <= 1'b0;
         padding_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         eom_pending_ff <= eom_pending_in;
         pad_first_ff   <= pad_first_in;
         pad_extra_ff   <= pad_extra_in;
         padding_ff     <= padding_in;
      end
   end

endmodule

// ===== hw/rtl/sha1s_datapath.sv =====
// ----------------------------------------------------------------------------
// sha1s_datapath
// block window, one-round-per-cycle compression, chaining value and length
// ----------------------------------------------------------------------------
module sha1s_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  sha1s_pkg::dp_cmd_type    cmd,
   input  logic [7:0]               data_byte,
   output sha1s_pkg::dp_status_type status,
   output logic [31:0]              digest_word,
   output logic [2:0]               word_number
);

   // 512-bit window: block bytes shift in at the bottom, word 0 ends on top;
   // during the rounds it serves as the rolling 16-word schedule
   logic [511:0] window_ff, window_in;
   logic [31:0]  work_ff [5];
   logic [31:0]  work_in [5];
   logic [31:0]  chain_ff [5];
   logic [31:0]  chain_in [5];
   logic [63:0]  len_ff, len_in;
   logic [5:0]   pos_ff, pos_in;
   logic [6:0]   round_ff, round_in;
   logic [2:0]   word_ff, word_in;

   logic [7:0]  shift_byte;
   logic [63:0] len_shift;
   logic [31:0] w_old, w_new, w_use;
   logic [31:0] f_val, k_val, t_val;
   logic [31:0] a_w, b_w, c_w, d_w, e_w;

   assign a_w = work_ff[0];
   assign b_w = work_ff[1];
   assign c_w = work_ff[2];
   assign d_w = work_ff[3];
   assign e_w = work_ff[4];

   assign len_shift = len_ff >> {~pos_ff[2:0], 3'b000};

   always_comb begin
      if (cmd.pad_byte) begin
         if (cmd.pad_first) begin
            shift_byte = sha1s_pkg::PAD_MARK;
         end else if (pos_ff >= 6'd56 && !cmd.pad_extra) begin
            shift_byte = len_shift[7:0];
         end else begin
            shift_byte = 8'h00;
         end
      end else begin
         shift_byte = data_byte;
      end
   end

   // schedule and round function
   assign w_old = window_ff[511:480];
   assign w_new = window_ff[95:64] ^ window_ff[255:224] ^ window_ff[447:416] ^ w_old;
   assign w_use = (round_ff < 7'd16) ? w_old : {w_new[30:0], w_new[31]};

   always_comb begin
      if (round_ff < 7'd20) begin
         f_val = (b_w & c_w) | (~b_w & d_w);
         k_val = sha1s_pkg::K_ROUND0;
      end else if (round_ff < 7'd40) begin
         f_val = b_w ^ c_w ^ d_w;
         k_val = sha1s_pkg::K_ROUND1;
      end else if (round_ff < 7'd60) begin
         f_val = (b_w & c_w) | (b_w & d_w) | (c_w & d_w);
         k_val = sha1s_pkg::K_ROUND2;
      end else begin
         f_val = b_w ^ c_w ^ d_w;
         k_val = sha1s_pkg::K_ROUND3;
      end
   end

   assign t_val = {a_w[26:0], a_w[31:27]} + f_val + e_w + k_val + w_use;

   always_comb begin
      window_in = window_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      round_in  = round_ff;
      word_in   = word_ff;
      for (int i = 0; i < 5; i++) begin
         work_in[i]  = work_ff[i];
         chain_in[i] = chain_ff[i];
      end

      if (cmd.load_byte || cmd.pad_byte) begin
         window_in = {window_ff[503:0], shift_byte};
         pos_in    = pos_ff + 6'd1;
      end
      if (cmd.load_byte) begin
         len_in = len_ff + 64'd8;
      end
      if (cmd.begin_block) begin
         round_in = '0;
         for (int i = 0; i < 5; i++) begin
            work_in[i] = chain_ff[i];
         end
      end
      if (cmd.round) begin
         window_in  = {window_ff[479:0], w_use};
         round_in   = round_ff + 7'd1;
         work_in[4] = d_w;
         work_in[3] = c_w;
         work_in[2] = {b_w[1:0], b_w[31:2]};
         work_in[1] = a_w;
         work_in[0] = t_val;
      end
      if (cmd.finish) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.emit_next) begin
         word_in = word_ff + 3'd1;
      end
      if (cmd.emit_done) begin
         word_in     = '0;
         len_in      = '0;
         chain_in[0] = sha1s_pkg::H0_INIT;
         chain_in[1] = sha1s_pkg::H1_INIT;
         chain_in[2] = sha1s_pkg::H2_INIT;
         chain_in[3] = sha1s_pkg::H3_INIT;
         chain_in[4] = sha1s_pkg::H4_INIT;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      for (int i = 0; i < 5; i++) begin
         work_ff[i] <= work_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         pos_ff      <= '0;
         round_ff    <= '0;
         word_ff     <= '0;
         chain_ff[0] <= sha1s_pkg::H0_INIT;
         chain_ff[1] <= sha1s_pkg::H1_INIT;
         chain_ff[2] <= sha1s_pkg::H2_INIT;
         chain_ff[3] <= sha1s_pkg::H3_INIT;
         chain_ff[4] <= sha1s_pkg::H4_INIT;
      end else begin
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         round_ff <= round_in;
         word_ff  <= word_in;
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   assign status.pos_last   = (pos_ff == 6'd63);
   assign status.pos_ge56   = (pos_ff >= 6'd56);
   assign status.round_last = (round_ff == 7'(sha1s_pkg::ROUNDS - 1));
   assign status.word_last  = (word_ff == 3'(sha1s_pkg::DIGEST_WORDS - 1));

   assign digest_word = chain_ff[word_ff];
   assign word_number = word_ff;

endmodule

// ===== hw/rtl/sha1_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// sha-1 over a byte stream, digest returned as five 32-bit words
// ----------------------------------------------------------------------------
// A message byte is taken per transaction with tuser set. Each 64th byte
// starts the compression, which runs 80 rounds on a single round unit
// followed by a chaining update. A transaction with tlast closes the
// message: padding is shifted in one byte per cycle up to the end of the
// block (one or two blocks, each followed by compression), then the five
// digest words leave one per cycle as the result side accepts them. No new
// request is taken from the close of a message until its last digest word
// has been accepted, nor during compression.
module sha1_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic        req_tuser,  // byte_present
   input  logic        req_tlast,  // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] digest_word, [34:32] word_number, rest zero
   output logic        rsp_tlast   // final_word
);

   sha1s_pkg::dp_cmd_type    cmd;
   sha1s_pkg::dp_status_type status;
   logic [31:0]              digest_word;
   logic [2:0]               word_number;

   sha1s_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   sha1s_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_tdata),
      .status      (status),
      .digest_word (digest_word),
      .word_number (word_number)
   );

   assign rsp_tdata = {5'b00000, word_number, digest_word};
   assign rsp_tlast = status.word_last;

endmodule
